// File: hw/rtl/thermal_shock_safety_interlock_core_assert.svh
// Assertion macros shared by the interlock RTL modules.
`ifndef THERMAL_SHOCK_SAFETY_INTERLOCK_CORE_ASSERT_SVH
`define THERMAL_SHOCK_SAFETY_INTERLOCK_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TSI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define TSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tsi_pkg.sv
// Types and constants of the thermal shock safety interlock.
package tsi_pkg;

  // Item operations
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SCRAM  = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  // Interlock modes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_WARNING = 2'd1;
  localparam logic [1:0] MODE_SCRAM   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LEVEL = 2'd1;

  localparam int unsigned TEMP_W  = 14;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned ACCEL_W = 12;
  localparam int unsigned PWR_W   = 7;
  localparam int unsigned PROD_W  = ADC_W + TEMP_W;

  localparam logic [TEMP_W-1:0]  WARN_LEVEL_RST    = 14'd960;
  localparam logic [TEMP_W-1:0]  CRIT_LEVEL_RST    = 14'd1280;
  localparam logic [TEMP_W-1:0]  TEMP_FULL_SCALE   = 14'd14850;
  localparam logic [ADC_W-1:0]   ADC_FULL_SCALE    = 12'd4095;
  localparam logic [TEMP_W-1:0]  TEMP_HYSTERESIS   = 14'd32;
  localparam logic [ACCEL_W-1:0] ACCEL_MAJOR       = 12'd512;
  localparam logic [ACCEL_W-1:0] ACCEL_MINOR       = 12'd204;
  localparam logic [PWR_W-1:0]   POWER_RESET       = 7'd50;
  localparam logic [PWR_W-1:0]   POWER_MAX         = 7'd100;

  // Default depth of the queue between front and back
  localparam int unsigned TSI_QDEPTH = 2;

  typedef struct packed {
    logic [TEMP_W-1:0] warn_level;
    logic [TEMP_W-1:0] crit_level;
  } tsi_cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        sample_number;
    logic [TEMP_W-1:0]  temp;
    logic [ACCEL_W-1:0] accel;
    logic               ok;
    logic               crit_hit;
    logic               warn_hit;
    logic               cooled;
    logic               major;
    logic               minor;
    logic [PWR_W-1:0]   power;
  } tsi_item_t;

endpackage

// File: hw/rtl/tsi_if.sv
// Channel interfaces of the thermal shock safety interlock.
interface tsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] sample_number;
  logic [11:0] adc_raw;
  logic        adc_ok;
  logic [11:0] accel_in;
  logic signed [31:0] power_request;

  modport source (output valid, operation, sample_number, adc_raw, adc_ok, accel_in,
                  power_request, input ready);
  modport sink (input valid, operation, sample_number, adc_raw, adc_ok, accel_in,
                power_request, output ready);
endinterface

interface tsi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_echo;
  logic [13:0] temperature;
  logic [11:0] accel_out;
  logic [1:0]  mode_out;
  logic [6:0]  power_out;
  logic        lamp;

  modport source (output valid, sample_echo, temperature, accel_out, mode_out, power_out,
                  lamp, input ready);
  modport sink (input valid, sample_echo, temperature, accel_out, mode_out, power_out,
                lamp, output ready);
endinterface

interface tsi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/thermal_shock_safety_interlock_core.sv
// Top level of the thermal shock safety interlock.
//
// Usage:
//   in_ch  carries sample and command beats: operation, sample_number, adc_raw,
//          adc_ok, accel_in and power_request. Sample beats convert the reading
//          to 1/16 degree C, step the normal/warning/scram state machine and
//          produce one telemetry beat; command beats (scram, reset, set power)
//          change state or power and produce no beat.
//   out_ch carries telemetry beats: sample_echo, temperature, accel_out,
//          mode_out, power_out and lamp, in the order the samples arrived.
//   cfg_ch writes the warning (index 0) and critical (index 1) thresholds;
//          it is always ready. Write it only while the block is idle.
// Throughput is one beat per cycle while out_ch accepts. On acceptance the
// product lands in the front register; the divide and classification then
// enter the queue, and the state update loads the output register from the
// queue head. Synchronous reset (rst_n low) returns mode to normal, power to
// 50, blink phase to 0, thresholds to their defaults and empties the pipeline.
// When out_ch stalls, the output register holds its beat, the queue fills,
// then the front stage fills and in_ready drops.
module thermal_shock_safety_interlock_core import tsi_pkg::*; #(
  parameter int unsigned QDEPTH = TSI_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  tsi_in_if.sink     in_ch,
  tsi_out_if.source  out_ch,
  tsi_cfg_if.sink    cfg_ch
);

  tsi_cfg_t  cfg_r;
  tsi_item_t push_data;
  tsi_item_t head_data;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // Threshold registers: always accept, drop writes to unknown indexes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_level <= WARN_LEVEL_RST;
      cfg_r.crit_level <= CRIT_LEVEL_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_WARN_LEVEL) begin
        cfg_r.warn_level <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_CRIT_LEVEL) begin
        cfg_r.crit_level <= cfg_ch.data;
      end
    end
  end

  // Front: accept, convert and classify
  tsi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  // Decouple front from back so each can stall on its own
  tsi_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (head_data)
  );

  // Back: advance the interlock state, register telemetry
  tsi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (head_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/tsi_front.sv
// Front end: accept items, convert the reading and classify against thresholds.
module tsi_front import tsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tsi_in_if.sink     in_ch,
  input  tsi_cfg_t   cfg,
  input  logic       q_full,
  output logic       q_push,
  output tsi_item_t  q_data
);

  localparam int unsigned ADC_SHIFT = ADC_W;

  logic               slot_v_r;
  logic [1:0]         op_r;
  logic [31:0]        sample_r;
  logic               ok_r;
  logic [ACCEL_W-1:0] accel_r;
  logic [PWR_W-1:0]   power_r;
  logic [PROD_W-1:0]  prod_r;

  logic               accept;
  logic [PWR_W-1:0]   power_nxt;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W-1:0]  est;
  logic [TEMP_W-1:0]  quot0;
  logic [PROD_W-1:0]  back_prod;
  logic [PROD_W-1:0]  rem;
  logic [TEMP_W-1:0]  temp;

  assign q_push      = slot_v_r && !q_full;
  assign in_ch.ready = !slot_v_r || q_push;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the requested power to 0..100
  always_comb begin
    if (in_ch.power_request[31]) begin
      power_nxt = '0;
    end else if (unsigned'(in_ch.power_request) > 32'(POWER_MAX)) begin
      power_nxt = POWER_MAX;
    end else begin
      power_nxt = in_ch.power_request[PWR_W-1:0];
    end
  end

  assign prod_nxt = PROD_W'(in_ch.adc_raw) * PROD_W'(TEMP_FULL_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else if (accept) begin
      slot_v_r <= 1'b1;
    end else if (q_push) begin
      slot_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.operation;
      sample_r <= in_ch.sample_number;
      ok_r     <= in_ch.adc_ok;
      accel_r  <= in_ch.accel_in;
      power_r  <= power_nxt;
      prod_r   <= prod_nxt;
    end
  end

  // Divide by 4095: estimate with p*(1 + 2^-12)/4096, then correct by one
  assign est       = prod_r + (prod_r >> ADC_SHIFT);
  assign quot0     = est[PROD_W-1:ADC_SHIFT];
  assign back_prod = {quot0, {ADC_SHIFT{1'b0}}} - PROD_W'(quot0);
  assign rem       = prod_r - back_prod;

  always_comb begin
    if (!ok_r) begin
      temp = '0;
    end else if (rem >= PROD_W'(ADC_FULL_SCALE)) begin
      temp = quot0 + TEMP_W'(1);
    end else begin
      temp = quot0;
    end
  end

  always_comb begin
    q_data.op            = op_r;
    q_data.sample_number = sample_r;
    q_data.temp          = temp;
    q_data.accel         = accel_r;
    q_data.ok            = ok_r;
    q_data.crit_hit      = temp >= cfg.crit_level;
    q_data.warn_hit      = temp >= cfg.warn_level;
    q_data.cooled        = ({1'b0, temp} + {1'b0, TEMP_HYSTERESIS}) < {1'b0, cfg.warn_level};
    q_data.major         = accel_r > ACCEL_MAJOR;
    q_data.minor         = accel_r > ACCEL_MINOR;
    q_data.power         = power_r;
  end

endmodule

// File: hw/rtl/tsi_queue.sv
// Short queue of classified items between the front end and the back end.
`include "thermal_shock_safety_interlock_core_assert.svh"
module tsi_queue import tsi_pkg::*; #(
  parameter int unsigned QDEPTH = TSI_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tsi_item_t wr_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output tsi_item_t rd_data
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  tsi_item_t        mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_FULL;
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `TSI_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_FULL, "queue count above depth")
  `TSI_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `TSI_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule

// File: hw/rtl/tsi_back.sv
// Back end: apply items to the interlock state and register telemetry beats.
`include "thermal_shock_safety_interlock_core_assert.svh"
module tsi_back import tsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  tsi_item_t q_head,
  output logic      q_pop,
  tsi_out_if.source out_ch
);

  logic [1:0]         mode_r;
  logic [PWR_W-1:0]   power_r;
  logic               blink_r;
  logic               out_valid_r;
  logic [31:0]        sample_r;
  logic [TEMP_W-1:0]  temp_r;
  logic [ACCEL_W-1:0] accel_r;
  logic [1:0]         mode_out_r;
  logic [PWR_W-1:0]   power_out_r;
  logic               lamp_r;

  logic [1:0]         mode_nxt;
  logic [PWR_W-1:0]   power_nxt;
  logic               blink_nxt;
  logic               lamp_nxt;
  logic               is_sample;

  assign q_pop     = !q_empty && (!out_valid_r || out_ch.ready);
  assign is_sample = q_head.op == OP_SAMPLE;

  always_comb begin
    mode_nxt  = mode_r;
    power_nxt = power_r;
    blink_nxt = blink_r;
    lamp_nxt  = 1'b0;
    unique case (q_head.op)
      OP_SCRAM: begin
        mode_nxt  = MODE_SCRAM;
        power_nxt = '0;
      end
      OP_RESET: begin
        mode_nxt  = MODE_NORMAL;
        power_nxt = POWER_RESET;
      end
      OP_SET: begin
        power_nxt = q_head.power;
      end
      OP_SAMPLE: begin
        // Failed read forces scram before the normal transitions
        if (!q_head.ok) begin
          mode_nxt  = MODE_SCRAM;
          power_nxt = '0;
        end
        unique case (mode_nxt)
          MODE_NORMAL: begin
            if (q_head.crit_hit || q_head.major) begin
              mode_nxt  = MODE_SCRAM;
              power_nxt = '0;
            end else if (q_head.warn_hit || q_head.minor) begin
              mode_nxt = MODE_WARNING;
            end
          end
          MODE_WARNING: begin
            if (q_head.crit_hit || q_head.major) begin
              mode_nxt  = MODE_SCRAM;
              power_nxt = '0;
            end else if (q_head.cooled) begin
              mode_nxt = MODE_NORMAL;
            end
          end
          default: begin
            mode_nxt  = MODE_SCRAM;
            power_nxt = '0;
          end
        endcase
        if (mode_nxt == MODE_WARNING) begin
          blink_nxt = ~blink_r;
          lamp_nxt  = ~blink_r;
        end else if (mode_nxt == MODE_SCRAM) begin
          lamp_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      power_r     <= POWER_RESET;
      blink_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r  <= mode_nxt;
        power_r <= power_nxt;
        blink_r <= blink_nxt;
      end
      if (q_pop && is_sample) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_sample) begin
      sample_r    <= q_head.sample_number;
      temp_r      <= q_head.temp;
      accel_r     <= q_head.accel;
      mode_out_r  <= mode_nxt;
      power_out_r <= power_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_echo = sample_r;
  assign out_ch.temperature = temp_r;
  assign out_ch.accel_out   = accel_r;
  assign out_ch.mode_out    = mode_out_r;
  assign out_ch.power_out   = power_out_r;
  assign out_ch.lamp        = lamp_r;

  `TSI_ASSERT_NEXT(a_scram_cmd, q_pop && q_head.op == OP_SCRAM,
                   mode_r == MODE_SCRAM && power_r == '0, "scram command not applied")
  `TSI_ASSERT_IMP(a_scram_beat, out_valid_r && mode_out_r == MODE_SCRAM,
                  lamp_r && power_out_r == '0, "scram beat with power or lamp off")
  `TSI_ASSERT_IMP(a_normal_lamp, out_valid_r && mode_out_r == MODE_NORMAL,
                  !lamp_r, "lamp lit in normal mode")

endmodule
